// File: hw/rtl/wcp_pkg.sv
// Shared types, constants and the harmonic weight table of the co-occurrence pair block.
`default_nettype none
package wcp_pkg;

	// Default configuration of the block
	localparam int MAX_WINDOW_DEF = 32;
	localparam int ID_BITS_DEF    = 20;

	// Register and weight formats
	localparam int WIN_BITS    = 6;
	localparam int WEIGHT_BITS = 17;

	localparam logic [WIN_BITS-1:0]    WIN_RESET = 6'd10;
	localparam logic [WEIGHT_BITS-1:0] Q_ONE     = 17'd65536;
	localparam logic [WEIGHT_BITS-1:0] Q_HALF    = 17'd32768;

	// Request from the sequencer to the pair unit
	typedef struct packed {
		logic                is_self;
		logic [WIN_BITS-1:0] distance;
	} pair_req_t;

	// round(65536 / d), halves rounded up, Q1.16
	function automatic logic [WEIGHT_BITS-1:0] harmonic_q16(input logic [WIN_BITS-1:0] d);
		logic [WEIGHT_BITS-1:0] w;
		unique case (d)
			6'd1:  w = 17'd65536;
			6'd2:  w = 17'd32768;
			6'd3:  w = 17'd21845;
			6'd4:  w = 17'd16384;
			6'd5:  w = 17'd13107;
			6'd6:  w = 17'd10923;
			6'd7:  w = 17'd9362;
			6'd8:  w = 17'd8192;
			6'd9:  w = 17'd7282;
			6'd10: w = 17'd6554;
			6'd11: w = 17'd5958;
			6'd12: w = 17'd5461;
			6'd13: w = 17'd5041;
			6'd14: w = 17'd4681;
			6'd15: w = 17'd4369;
			6'd16: w = 17'd4096;
			6'd17: w = 17'd3855;
			6'd18: w = 17'd3641;
			6'd19: w = 17'd3449;
			6'd20: w = 17'd3277;
			6'd21: w = 17'd3121;
			6'd22: w = 17'd2979;
			6'd23: w = 17'd2849;
			6'd24: w = 17'd2731;
			6'd25: w = 17'd2621;
			6'd26: w = 17'd2521;
			6'd27: w = 17'd2427;
			6'd28: w = 17'd2341;
			6'd29: w = 17'd2260;
			6'd30: w = 17'd2185;
			6'd31: w = 17'd2114;
			6'd32: w = 17'd2048;
			6'd33: w = 17'd1986;
			6'd34: w = 17'd1928;
			6'd35: w = 17'd1872;
			6'd36: w = 17'd1820;
			6'd37: w = 17'd1771;
			6'd38: w = 17'd1725;
			6'd39: w = 17'd1680;
			6'd40: w = 17'd1638;
			6'd41: w = 17'd1598;
			6'd42: w = 17'd1560;
			6'd43: w = 17'd1524;
			6'd44: w = 17'd1489;
			6'd45: w = 17'd1456;
			6'd46: w = 17'd1425;
			6'd47: w = 17'd1394;
			6'd48: w = 17'd1365;
			6'd49: w = 17'd1337;
			6'd50: w = 17'd1311;
			6'd51: w = 17'd1285;
			6'd52: w = 17'd1260;
			6'd53: w = 17'd1237;
			6'd54: w = 17'd1214;
			6'd55: w = 17'd1192;
			6'd56: w = 17'd1170;
			6'd57: w = 17'd1150;
			6'd58: w = 17'd1130;
			6'd59: w = 17'd1111;
			6'd60: w = 17'd1092;
			6'd61: w = 17'd1074;
			6'd62: w = 17'd1057;
			6'd63: w = 17'd1040;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/wcp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wcp_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/wcp_pair_unit.sv
// Pair unit: orders the two ids, looks up the weights and holds the output beat.
`default_nettype none
module wcp_pair_unit #(
	parameter int ID_BITS = wcp_pkg::ID_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire wcp_pkg::pair_req_t               req,
	input  wire logic [ID_BITS-1:0]               tok_id,
	input  wire logic [ID_BITS-1:0]               other_id,
	output logic                                  free,
	input  wire logic                             out_ready,
	output logic                                  out_valid,
	output logic [ID_BITS-1:0]                    low_id,
	output logic [ID_BITS-1:0]                    high_id,
	output logic                                  is_self,
	output logic [wcp_pkg::WEIGHT_BITS-1:0]       cooc_weight,
	output logic [wcp_pkg::WEIGHT_BITS-1:0]       marginal_weight,
	output logic                                  last
);
	import wcp_pkg::*;

	logic                   valid_q;
	logic [ID_BITS-1:0]     low_q, high_q;
	logic                   self_q;
	logic [WEIGHT_BITS-1:0] cw_q, mw_q;
	logic [ID_BITS-1:0]     partner;
	logic                   tok_lt;
	logic [WEIGHT_BITS-1:0] harm;

	// output slot can take a new beat this cycle
	assign free = !valid_q || out_ready;

	// shared compare and weight lookup
	assign partner = req.is_self ? tok_id : other_id;
	assign tok_lt  = tok_id < partner;
	assign harm    = harmonic_q16(req.distance);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			low_q  <= tok_lt ? tok_id : partner;
			high_q <= tok_lt ? partner : tok_id;
			self_q <= req.is_self;
			cw_q   <= req.is_self ? Q_HALF : harm;
			mw_q   <= req.is_self ? Q_ONE : harm;
		end
	end

	assign out_valid       = valid_q;
	assign low_id          = low_q;
	assign high_id         = high_q;
	assign is_self         = self_q;
	assign cooc_weight     = cw_q;
	assign marginal_weight = mw_q;
	assign last            = self_q;

	// a beat is only loaded into a free slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free) else $error("pair unit loaded while output stalled");

	// a stalled beat is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q) else $error("stalled beat lost");

	// ids leave ordered
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> low_q <= high_q) else $error("pair ids out of order");

endmodule
`default_nettype wire

// File: hw/rtl/windowed_cooccurrence_pairs_core.sv
// Sliding-window co-occurrence pair generator: sequencer, history RAM and pair unit.
//
// Input channel (in_valid/in_ready): one beat is a token (kind 0) or a sentence
// boundary (kind 1). Output channel (out_valid/out_ready): one pair per beat.
// For a token the block emits one pair for each kept token at distance 1 up to
// min(window length, MAX_WINDOW, tokens kept), nearest first, weight round(1/d)
// in Q1.16, then a self pair marked last. A boundary empties the window and
// emits nothing.
// Sequence: a token is accepted in ST_IDLE, then ST_PAIR loads its distance
// pairs and ST_SELF the self pair; in_ready is low until the self pair is
// loaded. A boundary is taken in ST_IDLE. The first pair enters the output
// register once that slot is free. The rate is set by the shared pair unit,
// which loads one pair per cycle into the single output register while it is
// free. When the receiver stalls, the sequencer holds and the output beat stays put.
// cfg_we/cfg_wdata write the window length; write only while idle.
// Reset clears the window, the fill count and sets the window length to 10.
`default_nettype none
module windowed_cooccurrence_pairs_core #(
	parameter int MAX_WINDOW = wcp_pkg::MAX_WINDOW_DEF,
	parameter int ID_BITS    = wcp_pkg::ID_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wcp_pkg::WIN_BITS-1:0]   cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           kind,
	input  wire logic [ID_BITS-1:0]             token_id,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ID_BITS-1:0]                  low_id,
	output logic [ID_BITS-1:0]                  high_id,
	output logic                                is_self,
	output logic [wcp_pkg::WEIGHT_BITS-1:0]     cooc_weight,
	output logic [wcp_pkg::WEIGHT_BITS-1:0]     marginal_weight,
	output logic                                last
);
	import wcp_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam logic [AW-1:0]       AddrLast = AW'(MAX_WINDOW - 1);
	localparam logic [CW-1:0]       FillMax  = CW'(MAX_WINDOW);
	localparam logic [WIN_BITS-1:0] MaxWin   = WIN_BITS'(MAX_WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PAIR = 3'b010,
		ST_SELF = 3'b100
	} state_t;

	state_t              state_q;
	logic [WIN_BITS-1:0] win_q;
	logic [CW-1:0]       fill_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       addr_q;
	logic [CW-1:0]       dist_q;
	logic [CW-1:0]       span_q;
	logic [ID_BITS-1:0]  tok_q;

	logic                accept;
	logic [WIN_BITS-1:0] span_a, span_b;
	logic [CW-1:0]       span_in;
	logic [AW-1:0]       addr_dec, head_inc;
	logic                ram_re, ram_we;
	logic [AW-1:0]       ram_raddr;
	logic [ID_BITS-1:0]  ram_rdata;
	logic                pu_free, pu_load;
	pair_req_t           pu_req;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	// span = min(window, store depth, kept tokens)
	assign span_a  = (win_q > MaxWin) ? MaxWin : win_q;
	assign span_b  = (span_a > WIN_BITS'(fill_q)) ? WIN_BITS'(fill_q) : span_a;
	assign span_in = span_b[CW-1:0];

	// circular pointer steps
	assign addr_dec = (addr_q == '0) ? AddrLast : addr_q - AW'(1);
	assign head_inc = (head_q == AddrLast) ? '0 : head_q + AW'(1);

	// pair unit requests
	assign pu_req.is_self  = (state_q == ST_SELF);
	assign pu_req.distance = WIN_BITS'(dist_q);
	assign pu_load         = pu_free && ((state_q == ST_PAIR) || (state_q == ST_SELF));

	// history reads: nearest entry on accept, then one step back per pair
	assign ram_re    = (accept && !kind && (span_in != '0))
	                 || ((state_q == ST_PAIR) && pu_load && (dist_q != span_q));
	assign ram_raddr = (state_q == ST_IDLE) ? head_q : addr_dec;
	assign ram_we    = (state_q == ST_SELF) && pu_load;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			head_q  <= '0;
			addr_q  <= '0;
			dist_q  <= '0;
			span_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind) begin
							fill_q <= '0;
						end else begin
							span_q  <= span_in;
							dist_q  <= CW'(1);
							addr_q  <= head_q;
							state_q <= (span_in != '0) ? ST_PAIR : ST_SELF;
						end
					end
				end
				ST_PAIR: begin
					if (pu_load) begin
						if (dist_q == span_q) begin
							state_q <= ST_SELF;
						end else begin
							dist_q <= dist_q + CW'(1);
							addr_q <= addr_dec;
						end
					end
				end
				ST_SELF: begin
					if (pu_load) begin
						head_q  <= head_inc;
						if (fill_q != FillMax) begin
							fill_q <= fill_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// token held for the whole item
	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= token_id;
		end
	end

	wcp_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head_inc),
		.wdata(tok_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	wcp_pair_unit #(
		.ID_BITS(ID_BITS)
	) u_pair (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (pu_load),
		.req            (pu_req),
		.tok_id         (tok_q),
		.other_id       (ram_rdata),
		.free           (pu_free),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.low_id         (low_id),
		.high_id        (high_id),
		.is_self        (is_self),
		.cooc_weight    (cooc_weight),
		.marginal_weight(marginal_weight),
		.last           (last)
	);

	// fill count never passes the store depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillMax) else $error("fill count beyond store depth");

	// distance stays within the span while pairing
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR) |-> (dist_q >= CW'(1)) && (dist_q <= span_q))
		else $error("distance outside span");

	// the history is written only when the self pair goes out
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (state_q == ST_IDLE)) else $error("history write out of sequence");

	// span never exceeds the tokens kept
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAIR) |-> (span_q <= fill_q)) else $error("span beyond fill");

endmodule
`default_nettype wire
